// ----- hw/rtl/timestamped_frame_queue_macros.svh -----
// Assertion macros for the timestamped frame queue checker.
// No dependencies; included by the checker file only.
`ifndef TIMESTAMPED_FRAME_QUEUE_MACROS_SVH
`define TIMESTAMPED_FRAME_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timestamped frame queue check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timestamped frame queue check failed");

`endif

// ----- hw/rtl/tfq_pkg.sv -----
// Shared constants, codes and controller/datapath structs for the frame queue.
// No dependencies.
package tfq_pkg;

  localparam int TIME_W        = 40;
  localparam int HANDLE_W      = 16;
  localparam int COUNT_W       = 5;
  localparam int DROP_W        = 4;
  localparam int MODE_W        = 3;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DROP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NEAR  = 3'd5;

  localparam logic [1:0] RD_HEAD = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_SCAN = 2'd2;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_DATA = 2'd1;
  localparam logic [1:0] SRC_BEST = 2'd2;

  typedef struct packed {
    logic       load_op;
    logic       push_write;
    logic       flush;
    logic       head_pop;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       scan_start;
    logic       scan_step;
    logic       scan_issue;
    logic       drop_inc;
    logic       emit;
    logic       emit_ok;
    logic [1:0] emit_src;
  } tfq_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              can_push;
    logic              empty;
    logic              count_gt1;
    logic              count_gt2;
    logic              drop_hit;
    logic              scan_last;
  } tfq_status_t;

endpackage

// ----- hw/rtl/tfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tfq_ctrl.sv -----
// Controller state machine of the frame queue: sequences each operation.
// Depends on tfq_pkg.
module tfq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tfq_pkg::tfq_status_t status,
  output tfq_pkg::tfq_cmd_t    cmd,
  output logic                busy
);
  import tfq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DROP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_LFIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_op = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_IDLE;
        case (status.mode)
          MODE_PUSH: begin
            cmd.push_write = status.can_push;
            cmd.emit       = 1'b1;
            cmd.emit_ok    = status.can_push;
          end
          MODE_POP, MODE_PEEK: begin
            if (status.empty) begin
              cmd.emit = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_next = S_READ;
            end
          end
          MODE_FLUSH: begin
            cmd.flush   = 1'b1;
            cmd.emit    = 1'b1;
            cmd.emit_ok = 1'b1;
          end
          MODE_DROP: begin
            if (status.count_gt1) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_next = S_DROP;
            end else begin
              cmd.emit    = 1'b1;
              cmd.emit_ok = 1'b1;
            end
          end
          MODE_NEAR: begin
            if (status.empty) begin
              cmd.emit = 1'b1;
            end else begin
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_HEAD;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            cmd.emit = 1'b1;
          end
        endcase
      end
      S_READ: begin
        cmd.emit     = 1'b1;
        cmd.emit_ok  = 1'b1;
        cmd.emit_src = SRC_DATA;
        cmd.head_pop = (status.mode == MODE_POP);
        state_next   = S_IDLE;
      end
      S_DROP: begin
        if (status.drop_hit) begin
          cmd.head_pop = 1'b1;
          cmd.drop_inc = 1'b1;
        end
        if (status.drop_hit && status.count_gt2) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end else begin
          cmd.emit    = 1'b1;
          cmd.emit_ok = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_LFIN;
        end else begin
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = RD_SCAN;
          cmd.scan_issue = 1'b1;
        end
      end
      S_LFIN: begin
        cmd.emit     = 1'b1;
        cmd.emit_ok  = 1'b1;
        cmd.emit_src = SRC_BEST;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tfq_datapath.sv -----
// Datapath of the frame queue: pointers, capacity, entry RAM, scan and result registers.
// Depends on tfq_pkg and tfq_ram.
module tfq_datapath #(
  parameter int DEPTH = tfq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tfq_pkg::tfq_cmd_t             cmd,
  output tfq_pkg::tfq_status_t          status,
  input  logic [tfq_pkg::MODE_W-1:0]    mode,
  input  logic [tfq_pkg::TIME_W-1:0]    time_us,
  input  logic [tfq_pkg::HANDLE_W-1:0]  frame_handle,
  input  logic                          cfg_wr_en,
  input  logic [tfq_pkg::COUNT_W-1:0]   cfg_wr_data,
  output logic                          done,
  output logic                          ok,
  output logic [tfq_pkg::HANDLE_W-1:0]  out_handle,
  output logic [tfq_pkg::TIME_W-1:0]    out_time_us,
  output logic [tfq_pkg::DROP_W-1:0]    dropped_count,
  output logic [tfq_pkg::COUNT_W-1:0]   occupancy,
  output logic                          is_full,
  output logic                          is_empty
);
  import tfq_pkg::*;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int SUM_W   = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
  localparam int ENTRY_W = TIME_W + HANDLE_W;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[IDX_W-1:0];
  endfunction

  logic [MODE_W-1:0]   op_mode;
  logic [TIME_W-1:0]   op_time;
  logic [HANDLE_W-1:0] op_handle;
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [COUNT_W-1:0]  cap;
  logic [COUNT_W-1:0]  scan_idx;
  logic [DROP_W-1:0]   drop_cnt;
  logic [DROP_W-1:0]   drop_cnt_next;
  logic [TIME_W-1:0]   best_d;
  logic [TIME_W-1:0]   best_time;
  logic [HANDLE_W-1:0] best_handle;

  logic [SUM_W-1:0]    eff_cap;
  logic [SUM_W-1:0]    cap_ext;
  logic [SUM_W-1:0]    head_ext;
  logic [IDX_W-1:0]    head_inc;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [TIME_W-1:0]   rd_time;
  logic [HANDLE_W-1:0] rd_handle;
  logic [TIME_W:0]     diff_up;
  logic [TIME_W-1:0]   diff_dn;
  logic [TIME_W-1:0]   time_gap;
  logic                take;

  assign cap_ext  = SUM_W'(cap);
  assign eff_cap  = (cap_ext < DEPTH_S) ? cap_ext : DEPTH_S;
  assign head_ext = SUM_W'(head);
  assign head_inc = wrap_slot(head_ext + SUM_W'(1));
  assign wr_addr  = wrap_slot(head_ext + SUM_W'(count));

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_NEXT: rd_addr = head_inc;
      RD_SCAN: rd_addr = wrap_slot(head_ext + SUM_W'(scan_idx));
      default: rd_addr = head;
    endcase
  end

  tfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push_write),
    .wr_addr (wr_addr),
    .wr_data ({op_time, op_handle}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_time   = rd_data[ENTRY_W-1:HANDLE_W];
  assign rd_handle = rd_data[HANDLE_W-1:0];
  assign diff_up   = {1'b0, rd_time} - {1'b0, op_time};
  assign diff_dn   = op_time - rd_time;
  assign time_gap  = diff_up[TIME_W] ? diff_dn : diff_up[TIME_W-1:0];
  assign take      = (scan_idx == COUNT_W'(1)) || (time_gap < best_d);

  assign status.mode      = op_mode;
  assign status.can_push  = SUM_W'(count) < eff_cap;
  assign status.empty     = (count == '0);
  assign status.count_gt1 = (count > COUNT_W'(1));
  assign status.count_gt2 = (count > COUNT_W'(2));
  assign status.drop_hit  = diff_up[TIME_W];
  assign status.scan_last = (scan_idx == count);

  always_comb begin
    count_next = count;
    head_next  = head;
    if (cmd.flush) begin
      count_next = '0;
      head_next  = '0;
    end else if (cmd.push_write) begin
      count_next = count + COUNT_W'(1);
    end else if (cmd.head_pop) begin
      count_next = count - COUNT_W'(1);
      head_next  = head_inc;
    end
  end

  always_comb begin
    drop_cnt_next = drop_cnt;
    if (cmd.drop_inc && (drop_cnt != '1)) begin
      drop_cnt_next = drop_cnt + DROP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      cap      <= CAP_RESET;
      done     <= 1'b0;
      scan_idx <= '0;
      drop_cnt <= '0;
    end else begin
      head <= head_next;
      count <= count_next;
      done <= cmd.emit;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (cmd.load_op) begin
        drop_cnt <= '0;
      end else begin
        drop_cnt <= drop_cnt_next;
      end
      if (cmd.scan_start) begin
        scan_idx <= COUNT_W'(1);
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode   <= mode;
      op_time   <= time_us;
      op_handle <= frame_handle;
    end
    if (cmd.scan_step && take) begin
      best_d      <= time_gap;
      best_time   <= rd_time;
      best_handle <= rd_handle;
    end
    if (cmd.emit) begin
      ok            <= cmd.emit_ok;
      dropped_count <= drop_cnt_next;
      occupancy     <= count_next;
      is_full       <= SUM_W'(count_next) >= eff_cap;
      is_empty      <= (count_next == '0);
      case (cmd.emit_src)
        SRC_DATA: begin
          out_handle  <= rd_handle;
          out_time_us <= rd_time;
        end
        SRC_BEST: begin
          out_handle  <= best_handle;
          out_time_us <= best_time;
        end
        default: begin
          out_handle  <= '0;
          out_time_us <= '0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/timestamped_frame_queue.sv -----
// Top level of the timestamped frame queue: controller plus datapath.
// Depends on tfq_pkg, tfq_ctrl, tfq_datapath (and tfq_ram below it).
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high and
//   busy low; mode, time_us and frame_handle are sampled then.
//   Result channel: done is high for exactly one cycle with ok, out_handle,
//   out_time_us, dropped_count, occupancy, is_full and is_empty; the receiver
//   cannot stall it and must take it in that cycle.
//   Configuration: cfg_wr_en with cfg_wr_data writes the capacity limit; write
//   only while busy is low and no result is pending.
// Sequence (accept edge to done cycle): push, flush, rejected or unknown
//   operations emit from dispatch; pop and peek add a RAM read; drop-before
//   examines entries; nearest scans all entries, one a cycle via the RAM read port.
//   A new command may be taken at the edge that ends the done cycle, so one
//   transaction occupies the block for exactly its latency.
// Reset: rst empties the queue and sets the capacity limit to 16; entry storage
//   is left as it is.
module timestamped_frame_queue #(
  parameter int DEPTH = tfq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tfq_pkg::MODE_W-1:0]    mode,
  input  logic [tfq_pkg::TIME_W-1:0]    time_us,
  input  logic [tfq_pkg::HANDLE_W-1:0]  frame_handle,
  input  logic                          cfg_wr_en,
  input  logic [tfq_pkg::COUNT_W-1:0]   cfg_wr_data,
  output logic                          done,
  output logic                          ok,
  output logic [tfq_pkg::HANDLE_W-1:0]  out_handle,
  output logic [tfq_pkg::TIME_W-1:0]    out_time_us,
  output logic [tfq_pkg::DROP_W-1:0]    dropped_count,
  output logic [tfq_pkg::COUNT_W-1:0]   occupancy,
  output logic                          is_full,
  output logic                          is_empty
);
  import tfq_pkg::*;

  tfq_cmd_t    cmd;
  tfq_status_t status;

  tfq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .time_us       (time_us),
    .frame_handle  (frame_handle),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .ok            (ok),
    .out_handle    (out_handle),
    .out_time_us   (out_time_us),
    .dropped_count (dropped_count),
    .occupancy     (occupancy),
    .is_full       (is_full),
    .is_empty      (is_empty)
  );

endmodule

// ----- hw/rtl/tfq_checker.sv -----
// Port-level checker for the timestamped frame queue, bound to the top level.
// Depends on tfq_pkg and timestamped_frame_queue_macros.svh.
`include "timestamped_frame_queue_macros.svh"

module tfq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          ok,
  input logic [tfq_pkg::HANDLE_W-1:0]  out_handle,
  input logic [tfq_pkg::TIME_W-1:0]    out_time_us,
  input logic [tfq_pkg::DROP_W-1:0]    dropped_count,
  input logic [tfq_pkg::COUNT_W-1:0]   occupancy,
  input logic                          is_empty
);
  import tfq_pkg::*;

  `TFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TFQ_ASSERT_NEXT(a_single_result, done, !done)
  `TFQ_ASSERT_NOW(a_empty_flag, done, is_empty == (occupancy == '0))
  `TFQ_ASSERT_NOW(a_fail_zero, done && !ok,
                  out_handle == '0 && out_time_us == '0 && dropped_count == '0)
  `TFQ_ASSERT_NOW(a_done_idle, done, !busy)

endmodule

bind timestamped_frame_queue tfq_checker u_checker (.*);

// ----- tb/timestamped_frame_queue_tb.sv -----
// Self-checking testbench for the timestamped frame queue top level.
// Depends on tfq_pkg and timestamped_frame_queue; drives directed then random
// transactions and checks every result against its own queue predictor or a fixed expected result.
module timestamped_frame_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
  localparam int QUIET_CYCLES = 24;
  localparam int OPS_PER_PHASE = 100;
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [TIME_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
    logic [DROP_W-1:0]   dropped;
    logic [COUNT_W-1:0]  occ;
    logic                full;
    logic                empty;
  } frame_result_t;

  typedef struct {
    logic [MODE_W-1:0]   op;
    logic [TIME_W-1:0]   stamp;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    frame_result_t       want;
  } queue_step_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode = '0;
  logic [TIME_W-1:0]   time_us = '0;
  logic [HANDLE_W-1:0] frame_handle = '0;
  logic                cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]  cfg_wr_data = '0;
  logic                done;
  logic                ok;
  logic [HANDLE_W-1:0] out_handle;
  logic [TIME_W-1:0]   out_time_us;
  logic [DROP_W-1:0]   dropped_count;
  logic [COUNT_W-1:0]  occupancy;
  logic                is_full;
  logic                is_empty;

  logic [TIME_W-1:0]   shadow_time [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] shadow_handle [QUEUE_DEPTH];
  int                  shadow_head = 0;
  int                  shadow_count = 0;
  int                  shadow_cap = 16;

  frame_result_t       pending_results [$];
  queue_step_t         directed_steps [$];
  logic [TIME_W-1:0]   next_stamp = '0;
  bit                  gaps_on = 1'b1;
  int                  mismatch_count = 0;
  int                  sent_count = 0;
  int                  checked_count = 0;
  int                  refused_pushes = 0;
  int                  saturated_drops = 0;

  always #6 clk = ~clk;

  timestamped_frame_queue #(.DEPTH(QUEUE_DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .time_us(time_us), .frame_handle(frame_handle), .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data), .done(done), .ok(ok), .out_handle(out_handle),
    .out_time_us(out_time_us), .dropped_count(dropped_count),
    .occupancy(occupancy), .is_full(is_full), .is_empty(is_empty)
  );

  function automatic frame_result_t make_result(logic r_ok, logic [HANDLE_W-1:0] r_handle,
      logic [TIME_W-1:0] r_stamp, logic [DROP_W-1:0] r_dropped, logic [COUNT_W-1:0] r_occ,
      logic r_full, logic r_empty);
    frame_result_t r;
    r = '{r_ok, r_handle, r_stamp, r_dropped, r_occ, r_full, r_empty};
    return r;
  endfunction

  task automatic apply_queue_op(input logic [MODE_W-1:0] op, input logic [TIME_W-1:0] ts,
      input logic [HANDLE_W-1:0] fh, output frame_result_t res);
    int eff, slot, best, removed;
    logic [TIME_W-1:0] delta, best_delta;
    res = '0;
    removed = 0;
    eff = (shadow_cap < QUEUE_DEPTH) ? shadow_cap : QUEUE_DEPTH;
    case (op)
      MODE_PUSH: begin
        if (shadow_count < eff) begin
          slot = (shadow_head + shadow_count) % QUEUE_DEPTH;
          shadow_time[slot] = ts;
          shadow_handle[slot] = fh;
          shadow_count++;
          res.ok = 1'b1;
        end else begin
          refused_pushes++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (shadow_count > 0) begin
          res.ok = 1'b1;
          res.handle = shadow_handle[shadow_head];
          res.stamp = shadow_time[shadow_head];
          if (op == MODE_POP) begin
            shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
            shadow_count--;
          end
        end
      end
      MODE_FLUSH: begin
        shadow_count = 0;
        shadow_head = 0;
        res.ok = 1'b1;
      end
      MODE_DROP: begin
        while (shadow_count > 1 && shadow_time[shadow_head] < ts) begin
          shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
          shadow_count--;
          removed++;
        end
        if (removed >= 15) saturated_drops++;
        res.dropped = (removed > 15) ? 4'd15 : DROP_W'(removed);
        res.ok = 1'b1;
      end
      MODE_NEAR: begin
        if (shadow_count > 0) begin
          best = shadow_head;
          best_delta = '0;
          for (int i = 0; i < shadow_count; i++) begin
            slot = (shadow_head + i) % QUEUE_DEPTH;
            delta = (shadow_time[slot] >= ts) ? shadow_time[slot] - ts : ts - shadow_time[slot];
            if (i == 0 || delta < best_delta) begin
              best_delta = delta;
              best = slot;
            end
          end
          res.ok = 1'b1;
          res.handle = shadow_handle[best];
          res.stamp = shadow_time[best];
        end
      end
      default: begin
      end
    endcase
    res.occ = COUNT_W'(shadow_count);
    res.full = (shadow_count >= eff);
    res.empty = (shadow_count == 0);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    if (mismatch_count < 40)
      $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 64'(occupancy), 64'd0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        checked_count++;
        if (ok !== want.ok) flag_mismatch("ok", 64'(ok), 64'(want.ok));
        if (out_handle !== want.handle)
          flag_mismatch("out_handle", 64'(out_handle), 64'(want.handle));
        if (out_time_us !== want.stamp)
          flag_mismatch("out_time_us", 64'(out_time_us), 64'(want.stamp));
        if (dropped_count !== want.dropped)
          flag_mismatch("dropped_count", 64'(dropped_count), 64'(want.dropped));
        if (occupancy !== want.occ) flag_mismatch("occupancy", 64'(occupancy), 64'(want.occ));
        if (is_full !== want.full) flag_mismatch("is_full", 64'(is_full), 64'(want.full));
        if (is_empty !== want.empty) flag_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
      end
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_op(input logic [MODE_W-1:0] op, input logic [TIME_W-1:0] ts,
      input logic [HANDLE_W-1:0] fh, input bit typed, input frame_result_t want);
    frame_result_t predicted;
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= op;
    time_us <= ts;
    frame_handle <= fh;
    do @(posedge clk); while (busy);
    apply_queue_op(op, ts, fh, predicted);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    sent_count++;
  endtask

  task automatic add_step(input logic [MODE_W-1:0] op, input logic [TIME_W-1:0] ts,
      input logic [HANDLE_W-1:0] fh, input bit typed, input frame_result_t want);
    queue_step_t s;
    s = '{op, ts, fh, typed, want};
    directed_steps.insert(directed_steps.size(), s);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= COUNT_W'(cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cap = cap & 'h1f;
  endtask

  function automatic logic [TIME_W-1:0] stamp_for(int style);
    logic [63:0] wide;
    case ($urandom_range(0, 15))
      0: return '0;
      1: return STAMP_MAX;
      default: begin
      end
    endcase
    if (style == 0) begin
      next_stamp = next_stamp + TIME_W'($urandom_range(1, 40000));
      return next_stamp;
    end
    if (style == 1) return TIME_W'($urandom_range(0, 63));
    wide = {$urandom, $urandom};
    return wide[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] target_for(int style);
    logic [TIME_W-1:0] e;
    if ($urandom_range(0, 9) == 0) return STAMP_MAX;
    if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
      e = shadow_time[(shadow_head + $urandom_range(0, shadow_count - 1)) % QUEUE_DEPTH];
      if ($urandom_range(0, 1) == 1) return e + TIME_W'($urandom_range(0, 3));
      return e - TIME_W'($urandom_range(0, 3));
    end
    return stamp_for(style);
  endfunction

  initial begin
    int caps [] = '{16, 1, 0, 31, 4, 16, 2, 17, 8, 0, 16, 3, 31};
    frame_result_t none;
    int style, r, phase_ops, fill;
    logic [MODE_W-1:0] op;
    logic [TIME_W-1:0] ts;
    none = '0;

    add_step(MODE_POP,     '0,        '0,       1, make_result(0, 0, 0, 0, 0, 0, 1));
    add_step(MODE_PEEK,    '0,        '0,       1, make_result(0, 0, 0, 0, 0, 0, 1));
    add_step(MODE_NEAR,    STAMP_MAX, '0,       1, make_result(0, 0, 0, 0, 0, 0, 1));
    add_step(MODE_DROP,    STAMP_MAX, '0,       1, make_result(1, 0, 0, 0, 0, 0, 1));
    add_step(MODE_SPARE_A, STAMP_MAX, '1,       1, make_result(0, 0, 0, 0, 0, 0, 1));
    add_step(MODE_SPARE_B, '0,        '0,       1, make_result(0, 0, 0, 0, 0, 0, 1));
    add_step(MODE_PUSH,    '0,        '0,       1, make_result(1, 0, 0, 0, 1, 0, 0));
    add_step(MODE_PUSH,    STAMP_MAX, '1,       1, make_result(1, 0, 0, 0, 2, 0, 0));
    add_step(MODE_PEEK,    STAMP_MAX, '1,       1, make_result(1, 0, 0, 0, 2, 0, 0));
    add_step(MODE_NEAR,    STAMP_MAX, '0,       1,
             make_result(1, '1, STAMP_MAX, 0, 2, 0, 0));
    add_step(MODE_NEAR,    40'h80_0000_0000, '0, 0, none);
    add_step(MODE_PUSH,    40'd10,    16'h00a1, 0, none);
    add_step(MODE_PUSH,    40'd30,    16'h00b2, 0, none);
    add_step(MODE_NEAR,    40'd20,    '0,       0, none);
    add_step(MODE_DROP,    40'd20,    '0,       0, none);
    add_step(MODE_POP,     '0,        '0,       0, none);
    add_step(MODE_DROP,    STAMP_MAX, '0,       0, none);
    add_step(MODE_SPARE_B, STAMP_MAX, '1,       0, none);
    add_step(MODE_FLUSH,   STAMP_MAX, '1,       1, make_result(1, 0, 0, 0, 0, 0, 1));
    add_step(MODE_POP,     '0,        '0,       1, make_result(0, 0, 0, 0, 0, 0, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[k])
      issue_op(directed_steps[k].op, directed_steps[k].stamp, directed_steps[k].handle,
               directed_steps[k].typed, directed_steps[k].want);

    foreach (caps[p]) begin
      settle();
      write_capacity(caps[p]);
      style = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      fill = $urandom_range(0, 18);
      phase_ops = 0;
      repeat (fill) begin
        issue_op(MODE_PUSH, stamp_for(style), 16'($urandom), 0, none);
        phase_ops++;
      end
      if ($urandom_range(0, 2) == 0) begin
        issue_op(MODE_DROP, STAMP_MAX, 16'($urandom), 0, none);
        phase_ops++;
      end
      while (phase_ops < OPS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 40) op = MODE_PUSH;
        else if (r < 52) op = MODE_POP;
        else if (r < 60) op = MODE_PEEK;
        else if (r < 63) op = MODE_FLUSH;
        else if (r < 76) op = MODE_DROP;
        else if (r < 94) op = MODE_NEAR;
        else op = ($urandom_range(0, 1) == 1) ? MODE_SPARE_A : MODE_SPARE_B;
        ts = (op == MODE_DROP || op == MODE_NEAR) ? target_for(style) : stamp_for(style);
        issue_op(op, ts, 16'($urandom), 0, none);
        if (op != MODE_SPARE_A && op != MODE_SPARE_B) phase_ops++;
      end
    end

    settle();
    $display("covered %0d transactions and %0d checked results over %0d capacity settings",
             sent_count, checked_count, caps.size());
    $display("%0d pushes refused, %0d drops reaching the count limit",
             refused_pushes, saturated_drops);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
